/* sv/e2c_pkg.sv */
`timescale 1ns / 1ps

package e2c_pkg;

   // Pipeline depth, input register to result register
   localparam int STAGES = 6;

   // Whole days: t / 86400 = (t >> 7) / 675, done as a reciprocal multiply
   localparam int              DAY_PRE_SHIFT = 7;
   localparam logic [25:0]     DAY_RECIP     = 26'd50903317;  // ceil(2^35 / 675)
   localparam int              DAY_SHIFT     = 35;
   localparam logic [16:0]     SECS_PER_DAY  = 17'd86400;

   // Day numbers are rebased to 1968-01-01 so that 4-year cycles line up
   localparam logic [15:0]     EPOCH_OFFSET  = 16'd731;
   // 2100 is not a leap year: from 2100-03-01 on, skip the missing Feb 29
   localparam logic [15:0]     SKIP_DAY      = 16'd47541;
   localparam logic [11:0]     YEAR_BASE     = 12'd1968;

   // 4-year cycle: d / 1461
   localparam logic [16:0]     CYCLE_RECIP   = 17'd91868;     // ceil(2^27 / 1461)
   localparam int              CYCLE_SHIFT   = 27;
   localparam logic [15:0]     CYCLE_DAYS    = 16'd1461;

   // Start of each year within a 4-year period; the leap year comes first
   localparam logic [10:0]     YEAR1_START   = 11'd366;
   localparam logic [10:0]     YEAR2_START   = 11'd731;
   localparam logic [10:0]     YEAR3_START   = 11'd1096;

   // Hour: s / 3600 = (s >> 4) / 225
   localparam int              HOUR_PRE_SHIFT = 4;
   localparam logic [13:0]     HOUR_RECIP    = 14'd9321;      // ceil(2^21 / 225)
   localparam int              HOUR_SHIFT    = 21;
   localparam logic [16:0]     SECS_PER_HOUR = 17'd3600;

   // Minute: s / 60 = (s >> 2) / 15
   localparam int              MIN_PRE_SHIFT = 2;
   localparam logic [10:0]     MIN_RECIP     = 11'd1093;      // ceil(2^14 / 15)
   localparam int              MIN_SHIFT     = 14;
   localparam logic [11:0]     SECS_PER_MIN  = 12'd60;

   // First day of each month, zero based, common year
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clock_type;

   // First day of month idx (0 = January), shifted by one after February in a leap year
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      base = MONTH_START[idx];
      if (leap && idx >= 4'd2) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

/* sv/e2c_split.sv */
`timescale 1ns / 1ps

// Stages 0 and 1: whole days and seconds of the day
module e2c_split (
   input  logic        clock,
   input  logic [1:0]  en,
   input  logic [31:0] epoch_seconds,
   output logic [15:0] day_num,
   output logic [16:0] tod_secs
);

   localparam int PROD_W = 32 - e2c_pkg::DAY_PRE_SHIFT + 26;

   logic [PROD_W-1:0] day_prod;
   logic [31:0]       t_ff;
   logic [15:0]       days_ff, days_in;
   logic [31:0]       day_secs, rem_secs;
   logic [15:0]       skip;
   logic [15:0]       day_num_ff, day_num_in;
   logic [16:0]       tod_ff, tod_in;

   // Stage 0: days by reciprocal multiply
   assign day_prod = PROD_W'(epoch_seconds[31:e2c_pkg::DAY_PRE_SHIFT])
                   * PROD_W'(e2c_pkg::DAY_RECIP);
   assign days_in  = day_prod[e2c_pkg::DAY_SHIFT+15:e2c_pkg::DAY_SHIFT];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff    <= epoch_seconds;
         days_ff <= days_in;
      end
   end

   // Stage 1: remainder seconds, rebase day count
   assign day_secs   = 32'(days_ff) * 32'(e2c_pkg::SECS_PER_DAY);
   assign rem_secs   = t_ff - day_secs;
   assign tod_in     = rem_secs[16:0];
   assign skip       = (days_ff >= e2c_pkg::SKIP_DAY) ? 16'd1 : 16'd0;
   assign day_num_in = days_ff + e2c_pkg::EPOCH_OFFSET + skip;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tod_ff     <= tod_in;
         day_num_ff <= day_num_in;
      end
   end

   assign day_num  = day_num_ff;
   assign tod_secs = tod_ff;

endmodule

/* sv/e2c_date.sv */
`timescale 1ns / 1ps

// Stages 2..5: day number since 1968-01-01 to year, month, day
module e2c_date (
   input  logic              clock,
   input  logic [3:0]        en,
   input  logic [15:0]       day_num,
   output e2c_pkg::date_type date
);

   logic [32:0]       cyc_prod;
   logic [15:0]       dnum_ff;
   logic [5:0]        cycle_ff, cycle_in;

   logic [15:0]       cyc_days, cyc_diff;
   logic [5:0]        cycle2_ff;
   logic [10:0]       cday_ff, cday_in;

   logic [1:0]        yidx;
   logic [10:0]       ystart;
   logic [11:0]       year_ff, year_in;
   logic [8:0]        doy_ff, doy_in;
   logic              leap_ff, leap_in;

   logic [3:0]        mcount;
   logic [8:0]        mday;
   e2c_pkg::date_type date_ff, date_in;

   // Stage 2: 4-year cycle index
   assign cyc_prod = 33'(day_num) * 33'(e2c_pkg::CYCLE_RECIP);
   assign cycle_in = cyc_prod[e2c_pkg::CYCLE_SHIFT+5:e2c_pkg::CYCLE_SHIFT];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dnum_ff  <= day_num;
         cycle_ff <= cycle_in;
      end
   end

   // Stage 3: day within the cycle
   assign cyc_days = 16'(cycle_ff) * e2c_pkg::CYCLE_DAYS;
   assign cyc_diff = dnum_ff - cyc_days;
   assign cday_in  = cyc_diff[10:0];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cycle2_ff <= cycle_ff;
         cday_ff   <= cday_in;
      end
   end

   // Stage 4: year within the cycle and day of year
   always_comb begin
      if (cday_ff < e2c_pkg::YEAR1_START) begin
         yidx   = 2'd0;
         ystart = 11'd0;
      end else if (cday_ff < e2c_pkg::YEAR2_START) begin
         yidx   = 2'd1;
         ystart = e2c_pkg::YEAR1_START;
      end else if (cday_ff < e2c_pkg::YEAR3_START) begin
         yidx   = 2'd2;
         ystart = e2c_pkg::YEAR2_START;
      end else begin
         yidx   = 2'd3;
         ystart = e2c_pkg::YEAR3_START;
      end
   end

   assign year_in = e2c_pkg::YEAR_BASE + 12'({cycle2_ff, 2'b00}) + 12'(yidx);
   assign doy_in  = 9'(cday_ff - ystart);
   assign leap_in = (yidx == 2'd0);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         year_ff <= year_in;
         doy_ff  <= doy_in;
         leap_ff <= leap_in;
      end
   end

   // Stage 5: month by parallel compares against month starts
   always_comb begin
      mcount = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy_ff >= e2c_pkg::month_start(4'(m), leap_ff)) begin
            mcount = mcount + 4'd1;
         end
      end
   end

   assign mday          = doy_ff - e2c_pkg::month_start(mcount, leap_ff) + 9'd1;
   assign date_in.year  = year_ff;
   assign date_in.month = mcount + 4'd1;
   assign date_in.day   = mday[4:0];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         date_ff <= date_in;
      end
   end

   assign date = date_ff;

endmodule

/* sv/e2c_clock.sv */
`timescale 1ns / 1ps

// Stages 2..5: seconds of the day to hour, minute, second
module e2c_clock (
   input  logic               clock,
   input  logic [3:0]         en,
   input  logic [16:0]        tod_secs,
   output e2c_pkg::clock_type hms
);

   localparam int HPROD_W = 17 - e2c_pkg::HOUR_PRE_SHIFT + 14;
   localparam int MPROD_W = 12 - e2c_pkg::MIN_PRE_SHIFT + 11;

   logic [HPROD_W-1:0] hour_prod;
   logic [16:0]        tod_ff;
   logic [4:0]         hour_ff, hour_in;

   logic [16:0]        hour_secs, hour_diff;
   logic [4:0]         hour2_ff;
   logic [11:0]        hrem_ff, hrem_in;

   logic [MPROD_W-1:0] min_prod;
   logic [4:0]         hour3_ff;
   logic [11:0]        hrem2_ff;
   logic [5:0]         minute_ff, minute_in;

   logic [11:0]        sec_diff;
   e2c_pkg::clock_type hms_ff, hms_in;

   // Stage 2: hour by reciprocal multiply
   assign hour_prod = HPROD_W'(tod_secs[16:e2c_pkg::HOUR_PRE_SHIFT])
                    * HPROD_W'(e2c_pkg::HOUR_RECIP);
   assign hour_in   = hour_prod[e2c_pkg::HOUR_SHIFT+4:e2c_pkg::HOUR_SHIFT];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tod_ff  <= tod_secs;
         hour_ff <= hour_in;
      end
   end

   // Stage 3: seconds within the hour
   assign hour_secs = 17'(hour_ff) * e2c_pkg::SECS_PER_HOUR;
   assign hour_diff = tod_ff - hour_secs;
   assign hrem_in   = hour_diff[11:0];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hour2_ff <= hour_ff;
         hrem_ff  <= hrem_in;
      end
   end

   // Stage 4: minute by reciprocal multiply
   assign min_prod  = MPROD_W'(hrem_ff[11:e2c_pkg::MIN_PRE_SHIFT])
                    * MPROD_W'(e2c_pkg::MIN_RECIP);
   assign minute_in = min_prod[e2c_pkg::MIN_SHIFT+5:e2c_pkg::MIN_SHIFT];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         hour3_ff  <= hour2_ff;
         hrem2_ff  <= hrem_ff;
         minute_ff <= minute_in;
      end
   end

   // Stage 5: leftover seconds
   assign sec_diff      = hrem2_ff - 12'(minute_ff) * e2c_pkg::SECS_PER_MIN;
   assign hms_in.hour   = hour3_ff;
   assign hms_in.minute = minute_ff;
   assign hms_in.second = sec_diff[5:0];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         hms_ff <= hms_in;
      end
   end

   assign hms = hms_ff;

endmodule

/* sv/epoch_seconds_to_calendar.sv */
`timescale 1ns / 1ps

// Converts an unsigned 32-bit Unix time (seconds since 1970-01-01 00:00:00 UTC)
// into the UTC calendar date and time of day, Gregorian rules, for every input
// value (up to 2106-02-07 06:28:15). Fully pipelined: one transaction per cycle
// in, one per cycle out while the result side does not stall. Six register
// stages, the first loaded at the accepting edge, the result taken from the last.
// The depth is set by the chain of constant reciprocal multiplies (days, 4-year
// cycle, hour, minute), each followed by a register and a multiply-subtract. A
// stall on the result side backs up through the stage valid bits; empty stages
// still take new transactions. No state is kept between transactions.
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   localparam int N = e2c_pkg::STAGES;

   logic [N-1:0]       valid_ff, valid_in;
   logic [N-1:0]       adv;
   logic [15:0]        day_num;
   logic [16:0]        tod_secs;
   e2c_pkg::date_type  date;
   e2c_pkg::clock_type hms;

   // Stage advance: a stage loads when empty or when the next one moves
   always_comb begin
      adv[N-1] = !valid_ff[N-1] || !rsp_stall;
      for (int k = N - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   // Valid bits travel with the data
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[N-1];

   e2c_split u_split (
      .clock         (clock),
      .en            (adv[1:0]),
      .epoch_seconds (req_epoch_seconds),
      .day_num       (day_num),
      .tod_secs      (tod_secs)
   );

   e2c_date u_date (
      .clock   (clock),
      .en      (adv[5:2]),
      .day_num (day_num),
      .date    (date)
   );

   e2c_clock u_clock (
      .clock    (clock),
      .en       (adv[5:2]),
      .tod_secs (tod_secs),
      .hms      (hms)
   );

   assign rsp_year   = date.year;
   assign rsp_month  = date.month;
   assign rsp_day    = date.day;
   assign rsp_hour   = hms.hour;
   assign rsp_minute = hms.minute;
   assign rsp_second = hms.second;

`ifndef SYNTH
   // Input side stalls only when every stage holds a transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled with an empty pipeline stage");

   // Date datapath stays in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= 12'd1970 && rsp_year <= 12'd2106 &&
                     rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1))
      else $error("date field out of range");

   // Time-of-day datapath stays in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("time field out of range");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned LAST_DAY      = 49710;   // day number of the largest timestamp
   localparam int          HANG_LIMIT    = 2000;    // cycles with no transaction on either side
   localparam int          RANDOM_ITEMS  = 275;     // per idling phase
   localparam int          TAIL_CYCLES   = 16;      // pipeline depth plus margin

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   logic          req_taken = 1'b0;
   idle_mode_type idle_mode = IDLE_NONE;

   logic [31:0]  pending_seconds[$];
   calendar_type expected_dates[$];

   int error_count    = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int quiet_cycles   = 0;

   epoch_seconds_to_calendar dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gregorian calendar helpers
   function automatic int unsigned leap_year(int unsigned y);
      if (y % 4 != 0) return 0;
      if (y % 100 != 0) return 1;
      return (y % 400 == 0) ? 1 : 0;
   endfunction

   function automatic int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
         2: begin
            return 28 + leap_year(y);
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // Expected calendar fields for one timestamp
   function automatic calendar_type civil_from_epoch(logic [31:0] t);
      calendar_type c;
      int unsigned  days;
      int unsigned  sod;
      int unsigned  y;
      int unsigned  m;
      days = t / SECS_PER_DAY;
      sod  = t % SECS_PER_DAY;
      y = 1970;
      while (days >= 365 + leap_year(y)) begin
         days -= 365 + leap_year(y);
         y++;
      end
      m = 1;
      while (m < 12 && days >= month_days(m, y)) begin
         days -= month_days(m, y);
         m++;
      end
      c.year   = y[11:0];
      c.month  = m[3:0];
      c.day    = 5'(days + 1);
      c.hour   = 5'(sod / 3600);
      c.minute = 6'((sod % 3600) / 60);
      c.second = 6'(sod % 60);
      return c;
   endfunction

   // Timestamp of a calendar date and time, clamped to the 32-bit range
   function automatic logic [31:0] epoch_of(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi, int unsigned s);
      longint days;
      longint secs;
      days = 0;
      for (int unsigned yy = 1970; yy < y; yy++) days += 365 + leap_year(yy);
      for (int unsigned mm = 1; mm < mo; mm++) days += month_days(mm, y);
      days += d - 1;
      secs = days * SECS_PER_DAY + h * 3600 + mi * 60 + s;
      if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
      return secs[31:0];
   endfunction

   function automatic logic [31:0] random_timestamp();
      int unsigned pick;
      int unsigned y;
      int unsigned mo;
      int unsigned d;
      longint      secs;
      pick = $urandom_range(99);
      if (pick < 45) begin
         return $urandom();
      end else if (pick < 65) begin
         // just around a midnight
         secs = longint'($urandom_range(LAST_DAY)) * SECS_PER_DAY - 2 + $urandom_range(4);
         if (secs < 0) secs = 0;
         if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
         return secs[31:0];
      end else if (pick < 85) begin
         // first or last day of a month, leap Februaries included
         y  = $urandom_range(2105, 1970);
         mo = $urandom_range(12, 1);
         d  = $urandom_range(1) ? 1 : month_days(mo, y);
         if ($urandom_range(1)) begin
            return epoch_of(y, mo, d, $urandom_range(23), $urandom_range(59), $urandom_range(59));
         end
         return ($urandom_range(1)) ? epoch_of(y, mo, d, 0, 0, 0) : epoch_of(y, mo, d, 23, 59, 59);
      end
      // top of the range, years 2105 and 2106
      return 32'hFFFF_FFFF - $urandom_range(32'h00FF_FFFF);
   endfunction

   function automatic logic sender_idles(idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            return $urandom_range(99) < 64;
         end
         IDLE_BOTH: begin
            return $urandom_range(99) < 34;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic receiver_stalls(idle_mode_type mode);
      case (mode)
         IDLE_RECEIVER: begin
            return $urandom_range(99) < 64;
         end
         IDLE_BOTH: begin
            return $urandom_range(99) < 34;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   task automatic check_field(string name, int unsigned exp_value, int unsigned act_value);
      if (exp_value != act_value) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_value, act_value);
         error_count++;
      end
   endtask

   // Waits at falling edges until every queued timestamp is sent and converted
   task automatic wait_drained();
      while (pending_seconds.size() != 0 || req_valid || expected_dates.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Driver: new transaction or idle at the falling edge, held while stalled
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (!reset && pending_seconds.size() != 0 && !sender_idles(idle_mode)) begin
            req_valid         <= 1'b1;
            req_epoch_seconds <= pending_seconds.pop_front();
         end else begin
            req_valid         <= 1'b0;
            req_epoch_seconds <= $urandom();
         end
      end
      rsp_stall <= reset ? 1'b0 : receiver_stalls(idle_mode);
   end

   // Monitor: check results, record accepted timestamps, watch for a hang
   always @(posedge clock) begin
      calendar_type want;
      logic         got_req;
      logic         got_rsp;
      got_req = req_valid && !req_stall && !reset;
      got_rsp = rsp_valid && !rsp_stall && !reset;
      req_taken <= got_req;

      if (got_rsp) begin
         if (expected_dates.size() == 0) begin
            $error("unexpected result transaction: %0d-%0d-%0d %0d:%0d:%0d",
                   rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second);
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            check_field("year",   want.year,   rsp_year);
            check_field("month",  want.month,  rsp_month);
            check_field("day",    want.day,    rsp_day);
            check_field("hour",   want.hour,   rsp_hour);
            check_field("minute", want.minute, rsp_minute);
            check_field("second", want.second, rsp_second);
            checked_count++;
         end
      end

      if (got_req) begin
         expected_dates.push_back(civil_from_epoch(req_epoch_seconds));
         accepted_count++;
      end

      quiet_cycles = (got_req || got_rsp) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  HANG_LIMIT, expected_dates.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, leap days, century rule, signed 32-bit wrap
      pending_seconds = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         epoch_of(1972, 2, 28, 23, 59, 59), epoch_of(1972, 2, 29, 12, 0, 0),
         epoch_of(1972, 3, 1, 0, 0, 0), epoch_of(1973, 3, 1, 0, 0, 0),
         epoch_of(1999, 12, 31, 23, 59, 59), epoch_of(2000, 1, 1, 0, 0, 0),
         epoch_of(2000, 2, 29, 23, 59, 59), epoch_of(2000, 12, 31, 23, 59, 59),
         epoch_of(2100, 2, 28, 23, 59, 59), epoch_of(2100, 3, 1, 0, 0, 0),
         epoch_of(2100, 12, 31, 23, 59, 59), 32'h7FFF_FFFF, 32'h8000_0000,
         32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
      };

      for (int ph = 0; ph < 4; ph++) begin
         idle_mode = idle_mode_type'(ph);
         for (int i = 0; i < RANDOM_ITEMS; i++) pending_seconds.push_back(random_timestamp());
         // the next phase is queued only once the pipeline is empty
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Converted %0d timestamps, %0d results checked, 1970 through 2106,",
               accepted_count, checked_count);
      $display("with no idling, sender gaps, receiver stalls and both together.");
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
